// ----- rtl/core/ssum_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssum_pkg: shared types and helpers for the sorted segment sum unit
// Field widths, row modes, the result record and the saturating add.
// ----------------------------------------------------------------------------
package ssum_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int ID_W        = 16;
	localparam int VAL_W       = 32;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int RL_W        = COL_W + 1;

	typedef logic [ID_W-1:0]         seg_id_t;
	typedef logic signed [VAL_W-1:0] q16_t;
	typedef logic [COL_W-1:0]        col_t;
	typedef logic [RL_W-1:0]         row_len_t;

	// Row mode, chosen at column 0 and held for the whole row
	typedef enum logic [1:0] {
		MODE_NEW      = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_DROP_ERR = 2'd2,
		MODE_DROP     = 2'd3
	} row_mode_t;

	// One result transaction
	typedef struct packed {
		logic    write_enable;
		seg_id_t out_segment;
		col_t    out_column;
		q16_t    sum_value;
		logic    order_error;
		logic    row_end;
	} result_t;

	// Column sum write request
	typedef struct packed {
		logic en;
		col_t addr;
		q16_t data;
	} sum_wr_t;

	// Add with clamp to the signed range instead of wrapping
	function automatic q16_t sat_add(input q16_t a, input q16_t b);
		logic signed [VAL_W:0] s;
		q16_t                  r;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			r = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = s[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ssum_col_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssum_col_mem: per-column running sum storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssum_col_mem (
	input  wire logic             clk,
	input  wire ssum_pkg::sum_wr_t wr,
	input  wire logic             rd_en,
	input  wire ssum_pkg::col_t    rd_addr,
	output ssum_pkg::q16_t         rd_data
);

	ssum_pkg::q16_t mem [ssum_pkg::MAX_COLUMNS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ssum_accum.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssum_accum: row mode decision and column accumulate
// Picks the row mode at column 0, forms the running sum, holds segment state.
// ----------------------------------------------------------------------------
module ssum_accum (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              commit,
	input  wire ssum_pkg::seg_id_t segment_id,
	input  wire ssum_pkg::q16_t    value,
	input  wire ssum_pkg::col_t    column,
	input  wire logic              last,
	input  wire ssum_pkg::q16_t    old_sum,
	output ssum_pkg::sum_wr_t      wr,
	output ssum_pkg::result_t      res
);

	ssum_pkg::seg_id_t   cur_seg_q;
	logic                seg_valid_q;
	ssum_pkg::row_mode_t row_mode_q;

	ssum_pkg::row_mode_t mode_now;
	ssum_pkg::seg_id_t   seg_now;
	logic                keep;
	ssum_pkg::q16_t      sum;

	always_comb begin
		mode_now = row_mode_q;
		seg_now  = cur_seg_q;
		if (column == '0) begin
			if (!seg_valid_q || segment_id > cur_seg_q) begin
				mode_now = ssum_pkg::MODE_NEW;
				seg_now  = segment_id;
			end else if (segment_id == cur_seg_q) begin
				// stay dropped until a higher id shows up
				mode_now = (row_mode_q == ssum_pkg::MODE_DROP_ERR ||
					row_mode_q == ssum_pkg::MODE_DROP) ? ssum_pkg::MODE_DROP
					: ssum_pkg::MODE_ADD;
			end else begin
				mode_now = ssum_pkg::MODE_DROP_ERR;
			end
		end
		keep = (mode_now == ssum_pkg::MODE_NEW) || (mode_now == ssum_pkg::MODE_ADD);
		sum  = (mode_now == ssum_pkg::MODE_NEW) ? value : ssum_pkg::sat_add(old_sum, value);

		wr.en   = commit && keep;
		wr.addr = column;
		wr.data = sum;

		res.write_enable = keep;
		res.out_segment  = keep ? seg_now : segment_id;
		res.out_column   = column;
		res.sum_value    = keep ? sum : '0;
		res.order_error  = (mode_now == ssum_pkg::MODE_DROP_ERR);
		res.row_end      = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_seg_q   <= '0;
			seg_valid_q <= 1'b0;
			row_mode_q  <= ssum_pkg::MODE_NEW;
		end else if (commit) begin
			cur_seg_q  <= seg_now;
			row_mode_q <= mode_now;
			if (mode_now == ssum_pkg::MODE_NEW) begin
				seg_valid_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/sorted_segment_sum_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_segment_sum_unit: streaming sorted segment sum, signed Q16.16
// Accumulates rows tagged with non-decreasing segment ids into column sums.
// ----------------------------------------------------------------------------
// Usage:
//   - Config channel (cfg_valid/cfg_ready, row_length) sets elements per row;
//     cfg_ready is always high. Write it only while the unit is idle.
//   - Input channel (in_valid/in_ready) takes one element per transaction,
//     columns counted from 0 in arrival order.
//   - Output channel (out_valid/out_ready) gives one result per element: a
//     write of the running column sum, or a drop (order_error on a lower id).
//   - Each input passes the element stage, then the result register, to
//     out_valid. Throughput: one element per cycle while out_ready is high,
//     set by one sum read and write each; a forward covers a same-edge write.
//   - When the receiver stalls, the result register holds and the element
//     stage keeps its item; in_ready drops once both are full and returns the
//     cycle out_ready comes back.
//   - Reset clears the column counter, segment state and valid flags and sets
//     row_length to 1. Column sums are not cleared: a row that adds to a
//     column never started since reset reads undefined data.
// ----------------------------------------------------------------------------
module sorted_segment_sum_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire ssum_pkg::row_len_t    row_length,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire ssum_pkg::seg_id_t     segment_id,
	input  wire ssum_pkg::q16_t        value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       write_enable,
	output ssum_pkg::seg_id_t          out_segment,
	output ssum_pkg::col_t             out_column,
	output ssum_pkg::q16_t             sum_value,
	output logic                       order_error,
	output logic                       row_end
);

	// config and column counter
	ssum_pkg::row_len_t row_len_q;
	ssum_pkg::row_len_t limit;
	ssum_pkg::col_t     col_q;
	logic               in_last;

	// element stage
	logic               valid_s1;
	ssum_pkg::seg_id_t  id_s1;
	ssum_pkg::q16_t     val_s1;
	ssum_pkg::col_t     col_s1;
	logic               last_s1;
	logic               fwd_s1;
	ssum_pkg::q16_t     fwd_data_s1;

	// result register
	logic               out_valid_q;
	ssum_pkg::result_t  res_q;

	logic               in_fire;
	logic               advance;
	ssum_pkg::q16_t     mem_rd;
	ssum_pkg::q16_t     old_sum;
	ssum_pkg::sum_wr_t  wr;
	ssum_pkg::result_t  res;

	assign cfg_ready = 1'b1;

	// Clamp the row length: zero acts as one, too large acts as the maximum.
	always_comb begin
		priority if (row_len_q == '0) begin
			limit = ssum_pkg::row_len_t'(1);
		end else if (row_len_q > ssum_pkg::row_len_t'(ssum_pkg::MAX_COLUMNS)) begin
			limit = ssum_pkg::row_len_t'(ssum_pkg::MAX_COLUMNS);
		end else begin
			limit = row_len_q;
		end
	end

	// Row ends where the column reaches the length minus one, or passed it.
	assign in_last = ({1'b0, col_q} + ssum_pkg::row_len_t'(1)) >= limit;

	// Advance the element stage whenever the result register frees up.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q <= ssum_pkg::row_len_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			row_len_q <= row_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (in_fire) begin
			col_q <= in_last ? '0 : col_q + ssum_pkg::col_t'(1);
		end
	end

	// Read the column sum as the element is taken in.
	ssum_col_mem u_col_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (in_fire),
		.rd_addr (col_q),
		.rd_data (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				// a write to the same column on this edge is missed by the read
				fwd_s1   <= wr.en && (wr.addr == col_q);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			id_s1       <= segment_id;
			val_s1      <= value;
			col_s1      <= col_q;
			last_s1     <= in_last;
			fwd_data_s1 <= wr.data;
		end
	end

	assign old_sum = fwd_s1 ? fwd_data_s1 : mem_rd;

	ssum_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (advance),
		.segment_id (id_s1),
		.value      (val_s1),
		.column     (col_s1),
		.last       (last_s1),
		.old_sum    (old_sum),
		.wr         (wr),
		.res        (res)
	);

	// Result register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_enable = res_q.write_enable;
	assign out_segment  = res_q.out_segment;
	assign out_column   = res_q.out_column;
	assign sum_value    = res_q.sum_value;
	assign order_error  = res_q.order_error;
	assign row_end      = res_q.row_end;

endmodule
`default_nettype wire

// ----- sim/sorted_segment_sum_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_segment_sum_unit_tb: self-checking bench for the segment sum unit
// Streams rows of Q16.16 elements with rising, repeated and falling segment
// ids, predicts every result transaction and checks it field by field, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module sorted_segment_sum_unit_tb;

	// Cycles without any transaction before the run is declared hung
	localparam int             STALL_LIMIT = 2000;
	localparam int             ID_TOP      = 65535;
	localparam ssum_pkg::q16_t Q_MAX       = 32'sh7FFF_FFFF;
	localparam ssum_pkg::q16_t Q_MIN       = 32'sh8000_0000;

	typedef struct packed {
		ssum_pkg::seg_id_t id;
		ssum_pkg::q16_t    val;
	} element_t;

	// How a generated row's id relates to the segment currently open
	typedef enum int {
		ROW_NEW_SEG,
		ROW_SAME_SEG,
		ROW_LOWER_SEG
	} row_kind_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	ssum_pkg::row_len_t row_length = 9'd1;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	ssum_pkg::seg_id_t  segment_id = '0;
	ssum_pkg::q16_t     value      = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic               write_enable;
	ssum_pkg::seg_id_t  out_segment;
	ssum_pkg::col_t     out_column;
	ssum_pkg::q16_t     sum_value;
	logic               order_error;
	logic               row_end;

	sorted_segment_sum_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.row_length   (row_length),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.segment_id   (segment_id),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.out_segment  (out_segment),
		.out_column   (out_column),
		.sum_value    (sum_value),
		.order_error  (order_error),
		.row_end      (row_end)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: the bench's own copy of the accumulator
	// ------------------------------------------------------------------
	ssum_pkg::q16_t      acc_sums [ssum_pkg::MAX_COLUMNS];
	ssum_pkg::seg_id_t   acc_segment    = '0;
	logic                acc_seg_seen   = 1'b0;
	int                  acc_column     = 0;
	ssum_pkg::row_mode_t acc_mode       = ssum_pkg::MODE_NEW;
	ssum_pkg::row_len_t  acc_row_length = 9'd1;

	// Work out the result of one accepted element and advance the state.
	function automatic ssum_pkg::result_t segment_sum_predict(input ssum_pkg::seg_id_t id,
		input ssum_pkg::q16_t val);
		ssum_pkg::result_t res;
		int                lim;
		longint            s;
		lim = acc_row_length;
		if (lim == 0) lim = 1;
		if (lim > ssum_pkg::MAX_COLUMNS) lim = ssum_pkg::MAX_COLUMNS;

		// Column 0 decides the mode for the whole row
		if (acc_column == 0) begin
			if (!acc_seg_seen || id > acc_segment) begin
				acc_mode     = ssum_pkg::MODE_NEW;
				acc_segment  = id;
				acc_seg_seen = 1'b1;
			end else if (id == acc_segment) begin
				// Once a row of this segment was dropped, drop the rest quietly
				if (acc_mode == ssum_pkg::MODE_DROP_ERR || acc_mode == ssum_pkg::MODE_DROP)
					acc_mode = ssum_pkg::MODE_DROP;
				else
					acc_mode = ssum_pkg::MODE_ADD;
			end else begin
				acc_mode = ssum_pkg::MODE_DROP_ERR;
			end
		end

		res             = '0;
		res.out_segment = id;
		res.out_column  = acc_column[ssum_pkg::COL_W-1:0];
		if (acc_mode == ssum_pkg::MODE_NEW || acc_mode == ssum_pkg::MODE_ADD) begin
			if (acc_mode == ssum_pkg::MODE_NEW) begin
				acc_sums[acc_column] = val;
			end else begin
				// Clamp to the signed 32-bit range instead of wrapping
				s = longint'(acc_sums[acc_column]) + longint'(val);
				if (s > longint'(Q_MAX)) s = longint'(Q_MAX);
				if (s < longint'(Q_MIN)) s = longint'(Q_MIN);
				acc_sums[acc_column] = s[31:0];
			end
			res.write_enable = 1'b1;
			res.out_segment  = acc_segment;
			res.sum_value    = acc_sums[acc_column];
		end
		res.order_error = (acc_mode == ssum_pkg::MODE_DROP_ERR);
		// A shortened row ends at the first column at or past the new end
		res.row_end = (acc_column + 1 >= lim);
		acc_column  = res.row_end ? 0 : acc_column + 1;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Shared queues and counters
	// ------------------------------------------------------------------
	element_t          elements_to_send [$];
	ssum_pkg::result_t results_due [$];
	// Elements queued but not yet accepted; the idle check relies on it
	// because the driver pops an element before the unit accepts it
	int       elements_in_flight = 0;
	int       queued_total       = 0;
	int       errors             = 0;
	int       idle_cycles        = 0;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Bias toward the rails so saturation shows up often
	function automatic ssum_pkg::q16_t pick_value();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return ssum_pkg::q16_t'(int'($urandom_range(0, 512)) - 256);
			3: return '0;
			default: return ssum_pkg::q16_t'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Input driver: feed queued elements, hold each until its transaction
	// ------------------------------------------------------------------
	element_t next_element;
	int       in_gap  = 0;
	int       in_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// Latch the row length on its own transaction
			if (cfg_valid && cfg_ready) begin
				acc_row_length = row_length;
			end
			if (in_valid && in_ready) begin
				results_due.push_back(segment_sum_predict(segment_id, value));
				elements_in_flight--;
			end
			// Only touch the payload once the slot is free
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (elements_to_send.size() != 0) begin
					next_element = elements_to_send.pop_front();
					in_valid     <= 1'b1;
					segment_id   <= next_element.id;
					value        <= next_element.val;
					if (in_calm > 0) begin
						in_calm <= in_calm - 1;
						in_gap  <= 0;
					end else begin
						in_gap <= pick_gap();
						if ($urandom_range(0, 15) == 0) in_calm <= $urandom_range(30, 80);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: check each result against the oldest prediction
	// ------------------------------------------------------------------
	ssum_pkg::result_t want;
	int                out_stall = 0;
	int                out_calm  = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result transaction with no prediction pending");
					errors++;
				end else begin
					want = results_due.pop_front();
					if (write_enable !== want.write_enable) begin
						$error("write_enable: expected %0d, got %0d",
							want.write_enable, write_enable);
						errors++;
					end
					if (out_segment !== want.out_segment) begin
						$error("out_segment: expected %0d, got %0d",
							want.out_segment, out_segment);
						errors++;
					end
					if (out_column !== want.out_column) begin
						$error("out_column: expected %0d, got %0d",
							want.out_column, out_column);
						errors++;
					end
					if (sum_value !== want.sum_value) begin
						$error("sum_value: expected %0d, got %0d",
							want.sum_value, sum_value);
						errors++;
					end
					if (order_error !== want.order_error) begin
						$error("order_error: expected %0d, got %0d",
							want.order_error, order_error);
						errors++;
					end
					if (row_end !== want.row_end) begin
						$error("row_end: expected %0d, got %0d", want.row_end, row_end);
						errors++;
					end
				end
			end
			// Stall at random, independent of out_valid, except in calm stretches
			if (out_stall > 0) begin
				out_ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else if (out_calm > 0) begin
				out_ready <= 1'b1;
				if (out_valid && out_ready) out_calm <= out_calm - 1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				out_stall <= pick_gap();
				if ($urandom_range(0, 15) == 0) out_calm <= $urandom_range(30, 80);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: drop the run if nothing moves for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	// Planned segment id and the number of columns ever written by a new
	// segment: an add row must never reach a column past that count,
	// since column sums come out of reset undefined
	int                 plan_seg     = 0;
	int                 plan_written = 0;
	ssum_pkg::row_len_t plan_len     = 9'd1;

	task automatic push_item(input ssum_pkg::seg_id_t id, input ssum_pkg::q16_t val);
		elements_to_send.push_back({id, val});
		elements_in_flight++;
		queued_total++;
	endtask

	function automatic int cols_per_row();
		if (plan_len == 0) return 1;
		if (plan_len > ssum_pkg::MAX_COLUMNS) return ssum_pkg::MAX_COLUMNS;
		return plan_len;
	endfunction

	task automatic push_row(input ssum_pkg::seg_id_t id);
		for (int c = 0; c < cols_per_row(); c++) push_item(id, pick_value());
	endtask

	// Block until every element is accepted and every result checked
	task automatic wait_idle();
		do @(posedge clk);
		while (elements_in_flight != 0 || results_due.size() != 0);
	endtask

	task automatic write_row_length(input ssum_pkg::row_len_t len);
		wait_idle();
		cfg_valid  <= 1'b1;
		row_length <= len;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		plan_len = len;
	endtask

	task automatic random_row(input bit first_in_phase);
		row_kind_t kind;
		int        r;
		int        id;
		r = $urandom_range(0, 99);
		if (first_in_phase && cols_per_row() > plan_written) kind = ROW_NEW_SEG;
		else if (r < 40) kind = ROW_NEW_SEG;
		else if (r < 75 || plan_seg == 0) kind = ROW_SAME_SEG;
		else kind = ROW_LOWER_SEG;

		case (kind)
			ROW_NEW_SEG: begin
				// Mostly small steps, a few big jumps to reach the high id bits
				if ($urandom_range(0, 99) < 85) id = plan_seg + $urandom_range(1, 3);
				else id = plan_seg + $urandom_range(1000, 12000);
				if (id > 64000) id = plan_seg + 1;
				plan_seg = id;
				if (cols_per_row() > plan_written) plan_written = cols_per_row();
			end
			ROW_SAME_SEG: id = plan_seg;
			default: id = $urandom_range(0, plan_seg - 1);
		endcase
		push_row(ssum_pkg::seg_id_t'(id));
	endtask

	task automatic random_phase(input ssum_pkg::row_len_t len);
		int rows;
		write_row_length(len);
		rows = $urandom_range(3, 10);
		for (int i = 0; i < rows; i++) random_row(i == 0);
	endtask

	function automatic ssum_pkg::row_len_t pick_row_length();
		case ($urandom_range(0, 9))
			0: return 9'd0;
			1, 8: return 9'd1;
			2: return 9'd2;
			3: return 9'd3;
			4: return 9'd4;
			5: return 9'd5;
			6: return 9'd8;
			7: return ssum_pkg::row_len_t'($urandom_range(6, 16));
			default: return ssum_pkg::row_len_t'($urandom_range(2, 7));
		endcase
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one-element rows at the reset row length; first id 0
		// opens a segment, then add past the top rail, swing back, and
		// pin at the bottom rail
		push_item(16'd0, Q_MAX);
		push_item(16'd0, 32'sd1);
		push_item(16'd0, Q_MIN);
		push_item(16'd0, Q_MIN);
		push_item(16'd0, -32'sd1);

		// Row length 0 acts as 1: lower id drops with error, equal id after
		// a drop stays dropped without error, another lower id flags again
		write_row_length(9'd0);
		push_item(16'd3, 32'sd0);
		push_item(16'd1, 32'sd7);
		push_item(16'd3, 32'sd9);
		push_item(16'd2, 32'sd11);
		push_item(16'd4, -32'sd5);

		// Four-column segment, then cut the row length in the middle of an
		// add row so the row ends on the column already past the new end
		write_row_length(9'd4);
		for (int c = 0; c < 4; c++) push_item(16'd5, pick_value());
		push_item(16'd5, pick_value());
		push_item(16'd5, pick_value());
		write_row_length(9'd2);
		push_item(16'd5, pick_value());
		push_item(16'd9, pick_value());
		push_item(16'd9, pick_value());
		plan_seg     = 9;
		plan_written = 4;

		// Random rows over many short row lengths
		while (queued_total < 150) random_phase(pick_row_length());

		// Longest row: a length past the column count clamps to it; the
		// first row opens every column, the second adds into every column
		write_row_length(9'd511);
		plan_seg     = plan_seg + 1;
		plan_written = ssum_pkg::MAX_COLUMNS;
		push_row(ssum_pkg::seg_id_t'(plan_seg));
		push_row(ssum_pkg::seg_id_t'(plan_seg));

		while (queued_total < 800) random_phase(pick_row_length());

		// Top id last, since no higher segment can follow it
		write_row_length(9'd3);
		push_row(ssum_pkg::seg_id_t'(ID_TOP));
		push_row(ssum_pkg::seg_id_t'(ID_TOP));
		push_row(ssum_pkg::seg_id_t'($urandom_range(0, ID_TOP - 1)));
		push_row(ssum_pkg::seg_id_t'(ID_TOP));

		wait_idle();
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
